/* rtl/bgr_pkg.sv */
// Shared types and constants for the Bayer GB12 to RGB888 demosaic block.
`timescale 1ns / 1ps

package bgr_pkg;

   localparam int RAW_BITS       = 12;
   localparam int CHAN_BITS      = 8;
   localparam int COLUMN_BITS    = 12;
   localparam int ROW_WIDTH_BITS = 13;

   localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 13'd2590;

   // Input item: one raw mosaic sample
   typedef struct packed {
      logic [RAW_BITS-1:0] raw_pixel;
      logic                start_of_frame;
   } bgr_req_type;

   // Result item: one RGB pixel
   typedef struct packed {
      logic [CHAN_BITS-1:0]   red;
      logic [CHAN_BITS-1:0]   green;
      logic [CHAN_BITS-1:0]   blue;
      logic [COLUMN_BITS-1:0] column;
      logic                   last_of_pair;
   } bgr_rsp_type;

   // What a sample is, seen from the output side
   typedef enum logic [1:0] {
      KIND_NONE,  // even-row sample, only written to the line buffer
      KIND_RED,   // odd row, even column: red site
      KIND_EMIT   // odd row, odd column: green site, gives a pixel pair
   } bgr_kind_type;

   // Registered item passed from the front end to the pair stage
   typedef struct packed {
      logic                   valid;
      bgr_kind_type           kind;
      logic [RAW_BITS-1:0]    pix;
      logic [COLUMN_BITS-1:0] col;
   } bgr_stage_type;

endpackage

/* rtl/bgr_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bgr_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bgr_front.sv */
// Front end: width register, row and column counters, even-row line buffer.
`timescale 1ns / 1ps

module bgr_front #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  bgr_pkg::bgr_req_type                  req_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bgr_pkg::ROW_WIDTH_BITS-1:0]    csr_data,
   input  logic                                  advance,
   output bgr_pkg::bgr_stage_type                stage,
   output logic [bgr_pkg::RAW_BITS-1:0]          store_rdata
);
   import bgr_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int AW  = $clog2(MAX_WIDTH + 1);
   localparam int XW  = (AW > ROW_WIDTH_BITS) ? AW : ROW_WIDTH_BITS;
   localparam int CAP = (MAX_WIDTH / 2) * 2;

   logic [ROW_WIDTH_BITS-1:0] row_width_ff;
   logic [CW-1:0]             col_ff;
   logic [CW-1:0]             col_in;
   logic [CW-1:0]             col_cur;
   logic                      odd_ff;
   logic                      odd_in;
   logic                      odd_cur;
   logic [XW-1:0]             width_act;
   logic [XW-1:0]             col_next;
   logic                      accept;
   bgr_stage_type             stage_ff;
   bgr_stage_type             stage_in;

   assign csr_ready = 1'b1;
   assign req_ready = !stage_ff.valid || advance;
   assign accept    = req_valid && req_ready;

   // Width rounded down to even, clamped to [2, CAP]
   always_comb begin
      width_act = XW'({row_width_ff[ROW_WIDTH_BITS-1:1], 1'b0});
      if (width_act < XW'(2)) begin
         width_act = XW'(2);
      end
      if (width_act > XW'(CAP)) begin
         width_act = XW'(CAP);
      end
   end

   // Start of frame forces row 0, column 0 for this sample
   always_comb begin
      col_cur  = req_data.start_of_frame ? '0 : col_ff;
      odd_cur  = req_data.start_of_frame ? 1'b0 : odd_ff;
      col_next = XW'(col_cur) + XW'(1);
      if (col_next >= width_act) begin
         col_in = '0;
         odd_in = !odd_cur;
      end else begin
         col_in = col_next[CW-1:0];
         odd_in = odd_cur;
      end
   end

   always_comb begin
      stage_in.valid = 1'b1;
      stage_in.pix   = req_data.raw_pixel;
      stage_in.col   = COLUMN_BITS'(col_cur);
      if (!odd_cur) begin
         stage_in.kind = KIND_NONE;
      end else if (!col_cur[0]) begin
         stage_in.kind = KIND_RED;
      end else begin
         stage_in.kind = KIND_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff   <= ROW_WIDTH_RESET;
         col_ff         <= '0;
         odd_ff         <= 1'b0;
         stage_ff.valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            row_width_ff <= csr_data;
         end
         if (accept) begin
            col_ff   <= col_in;
            odd_ff   <= odd_in;
            stage_ff <= stage_in;
         end else if (advance) begin
            stage_ff.valid <= 1'b0;
         end
      end
   end

   assign stage = stage_ff;

   // Even rows write, odd rows read the same column: G at red sites, B at green sites
   bgr_ram #(
      .WIDTH (RAW_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (accept && !odd_cur),
      .wr_addr (col_cur),
      .wr_data (req_data.raw_pixel),
      .rd_en   (accept && odd_cur),
      .rd_addr (col_cur),
      .rd_data (store_rdata)
   );

endmodule

/* rtl/bgr_pair.sv */
// Pair stage: holds red and even-row green, builds and sends the two pixels.
`timescale 1ns / 1ps

module bgr_pair (
   input  logic                         clock,
   input  logic                         reset,
   input  bgr_pkg::bgr_stage_type       stage,
   input  logic [bgr_pkg::RAW_BITS-1:0] store_rdata,
   output logic                         advance,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bgr_pkg::bgr_rsp_type         rsp_data
);
   import bgr_pkg::*;

   logic [RAW_BITS-1:0]    held_red_ff;
   logic [RAW_BITS-1:0]    held_green_ff;
   logic                   pair_valid_ff;
   logic                   right_ff;
   logic [CHAN_BITS-1:0]   red_ff;
   logic [CHAN_BITS-1:0]   blue_ff;
   logic [CHAN_BITS-1:0]   green_l_ff;
   logic [CHAN_BITS-1:0]   green_r_ff;
   logic [COLUMN_BITS-1:0] col_ff;
   logic                   can_load;
   logic                   load;

   // Buffer frees as the right pixel leaves
   assign can_load = !pair_valid_ff || (right_ff && rsp_ready);
   assign advance  = stage.valid && ((stage.kind != KIND_EMIT) || can_load);
   assign load     = stage.valid && (stage.kind == KIND_EMIT) && can_load;

   always_ff @(posedge clock) begin
      if (stage.valid && (stage.kind == KIND_RED)) begin
         held_red_ff   <= stage.pix;
         held_green_ff <= store_rdata;
      end
      if (load) begin
         red_ff     <= held_red_ff[RAW_BITS-1:RAW_BITS-CHAN_BITS];
         green_l_ff <= held_green_ff[RAW_BITS-1:RAW_BITS-CHAN_BITS];
         blue_ff    <= store_rdata[RAW_BITS-1:RAW_BITS-CHAN_BITS];
         green_r_ff <= stage.pix[RAW_BITS-1:RAW_BITS-CHAN_BITS];
         col_ff     <= stage.col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         right_ff      <= 1'b0;
      end else begin
         if (load) begin
            pair_valid_ff <= 1'b1;
            right_ff      <= 1'b0;
         end else if (pair_valid_ff && rsp_ready) begin
            if (right_ff) begin
               pair_valid_ff <= 1'b0;
            end else begin
               right_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid             = pair_valid_ff;
   assign rsp_data.red          = red_ff;
   assign rsp_data.blue         = blue_ff;
   assign rsp_data.green        = right_ff ? green_r_ff : green_l_ff;
   assign rsp_data.column       = right_ff ? col_ff : col_ff - COLUMN_BITS'(1);
   assign rsp_data.last_of_pair = right_ff;

endmodule

/* rtl/bayer_gb12_to_rgb888_unit.sv */
// Bayer GB 12-bit to RGB 8-8-8 nearest-neighbour demosaic, top level.
//
// req_*: one raw 12-bit sample per item in raster order; start_of_frame
//    marks the first sample of a frame and restarts row and column at zero.
// rsp_*: RGB pixels. Each odd-row, odd-column sample yields two items,
//    left (last_of_pair = 0) then right (last_of_pair = 1), sharing red,
//    blue and column pair; other samples yield nothing.
// csr_*: row width in pixels; write only while the block is idle. Odd
//    widths round down, values are clamped to 2 .. MAX_WIDTH.
// Throughput: one sample per cycle, sustained, with the receiver ready.
//    The line buffer is a single-write, single-read RAM, one access per item.
// Path: the left pixel passes the stage register, then the pair register,
//    which loads once the previous pair has gone; the right pixel is
//    offered in the cycle after the left one leaves.
// Reset (synchronous): counters to row 0, column 0, width to 2590, no
//    items in flight. The line buffer is not cleared; odd rows only read
//    entries the preceding even row wrote, unless the width grew in between.
// Stall: the pixel pair sits in an output register; while it waits, even
//    rows and red sites keep flowing. A green site blocks req_ready only
//    when the previous pair has not fully gone.
`timescale 1ns / 1ps

module bayer_gb12_to_rgb888_unit #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bgr_pkg::bgr_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bgr_pkg::bgr_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bgr_pkg::ROW_WIDTH_BITS-1:0] csr_data
);
   import bgr_pkg::*;

   bgr_stage_type       stage;
   logic [RAW_BITS-1:0] store_rdata;
   logic                advance;

   // counters, width register and line buffer
   bgr_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .advance     (advance),
      .stage       (stage),
      .store_rdata (store_rdata)
   );

   // held samples and the outgoing pixel pair
   bgr_pair u_pair (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .store_rdata (store_rdata),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

/* rtl/bgr_checker.sv */
// Port-level checks for the demosaic block, bound to its top level.
`timescale 1ns / 1ps

module bgr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bgr_pkg::bgr_rsp_type rsp_data
);
   import bgr_pkg::*;

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // right pixel follows the left one straight away
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_pair |=> rsp_valid && rsp_data.last_of_pair)
      else $error("right pixel missing after left");

   // both pixels of a pair share red, blue and adjacent columns
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_pair |=>
         rsp_data.red == $past(rsp_data.red) && rsp_data.blue == $past(rsp_data.blue)
         && rsp_data.column == COLUMN_BITS'($past(rsp_data.column) + COLUMN_BITS'(1)))
      else $error("pair mismatch");

   // nothing offered straight after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bayer_gb12_to_rgb888_unit bgr_checker u_bgr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* bench/bayer_gb12_to_rgb888_unit_tb.sv */
// Self-checking testbench for the Bayer GB12 to RGB888 demosaic unit.
`timescale 1ns / 1ps

module bayer_gb12_to_rgb888_unit_tb;
   import bgr_pkg::*;

   localparam int          LINE_DEPTH      = 4096;
   localparam int          LINE_BITS       = $clog2(LINE_DEPTH);
   localparam int unsigned RANDOM_ITEMS    = 420;
   // pipe: stage and pair registers; a little margin before touching the width
   localparam int unsigned DRAIN_CYCLES    = 6;
   // receiver hold-off long enough to back the pipe up into req_ready
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned PRESSURE_ITEMS  = 150;
   // even-row run after reset, and the run that fills the widest random row
   localparam int unsigned RESET_RUN_ITEMS = 40;
   localparam int unsigned FILL_ITEMS      = 64;
   localparam int unsigned WATCHDOG_LIMIT  = 3000;

   // hand-worked items, run at the narrowest width (two columns)
   typedef struct packed {
      logic [RAW_BITS-1:0]  raw;
      logic                 sof;
      logic                 pair;         // item closes a 2x2 block
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green_left;
      logic [CHAN_BITS-1:0] green_right;
      logic [CHAN_BITS-1:0] blue;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 23;

   // At two columns each 2x2 block is four items: G B (even row), R G (odd row).
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // all ones
      '{12'hFFF, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'hFFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'hFFF, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'hFFF, 1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      // all zeros
      '{12'h000, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h000, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h000, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00},
      // distinct samples: checks channel routing and the low-nibble drop
      '{12'h12F, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h34F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h56F, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h78F, 1'b0, 1'b1, 8'h56, 8'h12, 8'h78, 8'h34},
      // frame restarted twice in a row, second restart wins
      '{12'hABC, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'hDEF, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h0F0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h800, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h7FF, 1'b0, 1'b1, 8'h80, 8'hDE, 8'h7F, 8'h0F},
      // even row, then a restart where the odd row would begin
      '{12'h111, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h222, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h333, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h444, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h555, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{12'h666, 1'b0, 1'b1, 8'h55, 8'h33, 8'h66, 8'h44}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   bgr_req_type               req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   bgr_rsp_type               rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [ROW_WIDTH_BITS-1:0] csr_data;

   // idling switches, flipped per phase by the stimulus
   bit                        sender_idles   = 1'b0;
   bit                        receiver_idles = 1'b0;
   bit                        hold_output    = 1'b0;

   bgr_rsp_type               expected_pixels [$];
   int unsigned               mismatches     = 0;
   int unsigned               quiet_cycles   = 0;

   // demosaic state as the block should hold it
   logic [RAW_BITS-1:0]       line_store [LINE_DEPTH];
   int unsigned               column_now     = 0;
   bit                        odd_row        = 1'b0;
   logic [RAW_BITS-1:0]       red_sample     = '0;
   logic [ROW_WIDTH_BITS-1:0] width_copy     = ROW_WIDTH_RESET;

   bayer_gb12_to_rgb888_unit #(
      .MAX_WIDTH(LINE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly back-to-back, now and then a few cycles, rarely a long gap.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Width the block really uses: low bit dropped, clamped to 2 .. line depth.
   function automatic int unsigned active_width(input logic [ROW_WIDTH_BITS-1:0] setting);
      int unsigned w;
      w = 32'({setting[ROW_WIDTH_BITS-1:1], 1'b0});
      if (w < 2) w = 2;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
   endfunction

   // Advances the demosaic state by one accepted sample; returns 1 when the
   // sample is an odd-row green site, with the left/right pixels it produces.
   function automatic bit demosaic_sample(input bgr_req_type sample,
                                          output bgr_rsp_type left_px,
                                          output bgr_rsp_type right_px);
      int unsigned col;
      int unsigned w;
      bit          pair;
      w        = active_width(width_copy);
      pair     = 1'b0;
      left_px  = '0;
      right_px = '0;
      if (sample.start_of_frame) begin
         column_now = 0;
         odd_row    = 1'b0;
      end
      col = column_now;
      if (!odd_row) begin
         line_store[LINE_BITS'(col)] = sample.raw_pixel;
      end else if (col[0] == 1'b0) begin
         red_sample = sample.raw_pixel;
      end else begin
         // both pixels share red and blue; green differs per side
         left_px.red          = red_sample[RAW_BITS-1:4];
         left_px.green        = line_store[LINE_BITS'(col - 1)][RAW_BITS-1:4];
         left_px.blue         = line_store[LINE_BITS'(col)][RAW_BITS-1:4];
         left_px.column       = COLUMN_BITS'(col - 1);
         left_px.last_of_pair = 1'b0;
         right_px              = left_px;
         right_px.green        = sample.raw_pixel[RAW_BITS-1:4];
         right_px.column       = COLUMN_BITS'(col);
         right_px.last_of_pair = 1'b1;
         pair = 1'b1;
      end
      col++;
      // a shrunk width ends the row as soon as the count reaches or passes it
      if (col >= w) begin
         column_now = 0;
         odd_row    = ~odd_row;
      end else begin
         column_now = col;
      end
      return pair;
   endfunction

   // Offers one item (called at a falling edge) and books what it should
   // produce. Typed rows supply their own expected pair; the state still
   // advances through the predictor.
   task automatic offer_sample(input bgr_req_type sample, input bit typed,
                               input bgr_rsp_type typed_left,
                               input bgr_rsp_type typed_right);
      int unsigned gap;
      bgr_rsp_type left_px;
      bgr_rsp_type right_px;
      gap = sender_idles ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = sample;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      if (demosaic_sample(sample, left_px, right_px)) begin
         expected_pixels.push_back(typed ? typed_left : left_px);
         expected_pixels.push_back(typed ? typed_right : right_px);
      end
      @(negedge clock);
   endtask

   // Random samples; optionally opening a frame, with sporadic restarts.
   task automatic stream_pixels(input int unsigned count, input bit open_frame,
                                input int unsigned restart_pct);
      bgr_req_type sample;
      for (int unsigned i = 0; i < count; i++) begin
         sample.raw_pixel      = RAW_BITS'($urandom);
         sample.start_of_frame = (i == 0 && open_frame) ||
                                 ($urandom_range(0, 99) < restart_pct);
         offer_sample(sample, 1'b0, '0, '0);
      end
   endtask

   // Lets everything booked come out, then a few cycles for red sites and
   // even-row items still in the pipe.
   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_row_width(input logic [ROW_WIDTH_BITS-1:0] value);
      wait_for_drain();
      csr_data  = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      width_copy = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : stimulus
      directed_row_type row;
      bgr_req_type      sample;
      bgr_rsp_type      typed_left;
      bgr_rsp_type      typed_right;
      int unsigned      random_done;
      int unsigned      w;
      int unsigned      count;
      bit               mid_row;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Straight out of reset, no frame start: counters come up at row 0,
      // column 0, so a short run at the reset width is all even row and
      // gives nothing.
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      stream_pixels(RESET_RUN_ITEMS, 1'b0, 0);

      // Hand-worked items. Register value zero acts as the minimum width.
      write_row_width('0);
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row                        = directed_rows[r];
         sample.raw_pixel           = row.raw;
         sample.start_of_frame      = row.sof;
         typed_left.red             = row.red;
         typed_left.green           = row.green_left;
         typed_left.blue            = row.blue;
         typed_left.column          = '0;
         typed_left.last_of_pair    = 1'b0;
         typed_right                = typed_left;
         typed_right.green          = row.green_right;
         typed_right.column         = COLUMN_BITS'(1);
         typed_right.last_of_pair   = 1'b1;
         offer_sample(sample, row.pair, typed_left, typed_right);
      end

      // All-ones register clamps to the line depth, so a short run from a
      // frame start stays in the even row. It fills the line-buffer entries
      // of the widest random row, so later width changes, mid-row ones
      // included, never read an unwritten entry.
      write_row_width('1);
      sender_idles = 1'b0;
      stream_pixels(FILL_ITEMS, 1'b1, 0);

      // Backpressure: receiver stalls for a long stretch while the sender
      // keeps offering; green sites then stall req_ready.
      write_row_width(ROW_WIDTH_BITS'(8));
      receiver_idles = 1'b0;
      hold_output    = 1'b1;
      stream_pixels(PRESSURE_ITEMS, 1'b1, 0);

      // Random part: mostly whole frames at assorted widths (odd ones and
      // below-minimum ones too); some runs stop mid-row and open no frame,
      // so they carry on where the last run left off and the next width
      // write lands mid-row. A few frame starts are dropped in at random.
      random_done = 0;
      while (random_done < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
               0:       write_row_width(ROW_WIDTH_BITS'($urandom_range(0, 1)));
               1:       write_row_width(ROW_WIDTH_BITS'($urandom_range(25, FILL_ITEMS)));
               default: write_row_width(ROW_WIDTH_BITS'($urandom_range(2, 24)));
            endcase
         end
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         w       = active_width(width_copy);
         count   = w * ((w > 24) ? 2 : $urandom_range(2, 6));
         mid_row = ($urandom_range(0, 9) < 4);
         if (mid_row) count = $urandom_range(1, count);
         if (count > RANDOM_ITEMS - random_done) count = RANDOM_ITEMS - random_done;
         stream_pixels(count, !mid_row, 2);
         random_done += count;
      end

      wait_for_drain();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin : output_side
      int unsigned stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_output) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
         end
         stall     = receiver_idles ? pick_gap() : 0;
         rsp_ready = (stall == 0);
         if (stall > 1) repeat (stall - 1) @(negedge clock);
      end
   end

   // Every accepted pixel against the oldest booked one, field by field.
   always @(posedge clock) begin : pixel_check
      bgr_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_pixels.size() == 0) begin
            $error("pixel with nothing expected: %h", rsp_data);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.red !== want.red) begin
               $error("red: expected %0h, got %0h", want.red, rsp_data.red);
               mismatches++;
            end
            if (rsp_data.green !== want.green) begin
               $error("green: expected %0h, got %0h", want.green, rsp_data.green);
               mismatches++;
            end
            if (rsp_data.blue !== want.blue) begin
               $error("blue: expected %0h, got %0h", want.blue, rsp_data.blue);
               mismatches++;
            end
            if (rsp_data.column !== want.column) begin
               $error("column: expected %0d, got %0d", want.column, rsp_data.column);
               mismatches++;
            end
            if (rsp_data.last_of_pair !== want.last_of_pair) begin
               $error("last_of_pair: expected %0b, got %0b",
                      want.last_of_pair, rsp_data.last_of_pair);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: too long without any handshake on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

/* filelist.f */
rtl/bgr_pkg.sv
rtl/bgr_ram.sv
rtl/bgr_front.sv
rtl/bgr_pair.sv
rtl/bayer_gb12_to_rgb888_unit.sv
rtl/bgr_checker.sv
bench/bayer_gb12_to_rgb888_unit_tb.sv
